/* design/isu_pkg.sv */
package isu_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 64;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_GET     = 3'd2,
    OP_SET     = 3'd3,
    OP_SEEK    = 3'd4,
    OP_INSERT  = 3'd5,
    OP_REMOVE  = 3'd6,
    OP_REVERSE = 3'd7
  } isu_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } isu_stat_t;

  typedef enum logic [2:0] {
    A_HOLD,
    A_WRITE,
    A_INSERT,
    A_REMOVE,
    A_ROTATE
  } isu_act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEEK,
    S_REV,
    S_FIN
  } isu_state_t;

  typedef struct packed {
    isu_act_t           act;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   cnt;
    logic [IDX_W-1:0]   rd_idx;
    logic [DATA_W-1:0]  val;
  } isu_cmd_t;

endpackage

/* design/indexed_sequence_store_unit.sv */
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    operation, position_in, item_value
// out      source     out_valid/out_ready  result_value, found_position, list_length, status
//
// Push, pop, get, set, insert and remove finish in the accept cycle; seek ends in S_SEEK.
// Reverse of n > 1 elements runs as accept, n-1 rotate passes, then result.
// One item is in work at a time; a result waiting for out_ready blocks the input.
// Synchronous active-high reset empties the sequence; cell contents are not cleared.
// A stalled output holds the result and blocks acceptance of the next item.
module indexed_sequence_store_unit #(
  parameter int unsigned CAPACITY = isu_pkg::DEFAULT_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  operation,
  input  logic [isu_pkg::POS_W-1:0]   position_in,
  input  logic signed [isu_pkg::DATA_W-1:0] item_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [isu_pkg::DATA_W-1:0] result_value,
  output logic signed [isu_pkg::POS_W-1:0]  found_position,
  output logic [isu_pkg::POS_W-1:0]   list_length,
  output logic [isu_pkg::STAT_W-1:0]  status
);
  import isu_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] CAP_N = IDX_W'(CAPACITY);
  localparam logic [IDX_W-1:0] ONE_N = IDX_W'(1);

  isu_state_t state, state_next;
  logic [CW-1:0]     count;
  logic [IDX_W-1:0]  count_next;
  logic [IDX_W-1:0]  lim, lim_next;
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] first_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [DATA_W-1:0] rd_data;
  isu_cmd_t          cmd;

  logic              out_free;
  logic              load_out;
  logic [DATA_W-1:0] res_n;
  logic [POS_W-1:0]  found_n;
  isu_stat_t         stat_n;
  logic [IDX_W-1:0]  n;
  logic [IDX_W-1:0]  pos;

  assign n = IDX_W'(count);
  assign pos = IDX_W'(position_in);
  assign out_free = !out_valid || out_ready;

  isu_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .match   (match_vec),
    .rd_data (rd_data)
  );

  assign first_hit = match_q & (~match_q + CAPACITY'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= CW'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    lim <= lim_next;
    if (state == S_IDLE) match_q <= match_vec;
  end

  always_comb begin
    state_next = state;
    count_next = n;
    lim_next = lim;
    in_ready = 1'b0;
    load_out = 1'b0;
    res_n = '0;
    found_n = '0;
    stat_n = STAT_OK;
    cmd.act = A_HOLD;
    cmd.pos = pos;
    cmd.cnt = n;
    cmd.rd_idx = pos;
    cmd.val = item_value;
    case (state)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          load_out = 1'b1;
          case (isu_op_t'(operation))
            OP_PUSH: begin
              if (n == CAP_N) begin
                stat_n = STAT_FULL;
              end else begin
                cmd.act = A_WRITE;
                cmd.pos = n;
                count_next = n + ONE_N;
              end
            end
            OP_POP: begin
              cmd.rd_idx = n - ONE_N;
              if (n == '0) begin
                stat_n = STAT_BAD;
              end else begin
                res_n = rd_data;
                count_next = n - ONE_N;
              end
            end
            OP_GET, OP_SET: begin
              if (pos >= n) begin
                stat_n = STAT_BAD;
              end else begin
                res_n = rd_data;
                if (isu_op_t'(operation) == OP_SET) cmd.act = A_WRITE;
              end
            end
            OP_SEEK: begin
              load_out = 1'b0;
              state_next = S_SEEK;
            end
            OP_INSERT: begin
              if (pos > n) begin
                stat_n = STAT_BAD;
              end else if (n == CAP_N) begin
                stat_n = STAT_FULL;
              end else begin
                cmd.act = A_INSERT;
                count_next = n + ONE_N;
              end
            end
            OP_REMOVE: begin
              if (pos >= n) begin
                stat_n = STAT_BAD;
              end else begin
                res_n = rd_data;
                cmd.act = A_REMOVE;
                count_next = n - ONE_N;
              end
            end
            default: begin
              if (n > ONE_N) begin
                load_out = 1'b0;
                lim_next = n - ONE_N;
                state_next = S_REV;
              end
            end
          endcase
        end
      end
      S_SEEK: begin
        if (out_free) begin
          load_out = 1'b1;
          found_n = (match_q == '0) ? '1 : hit_idx[POS_W-1:0];
          state_next = S_IDLE;
        end
      end
      S_REV: begin
        cmd.act = A_ROTATE;
        cmd.pos = lim;
        lim_next = lim - ONE_N;
        if (lim == ONE_N) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= res_n;
      found_position <= found_n;
      list_length <= count_next[POS_W-1:0];
      status <= stat_n;
    end
  end

endmodule

/* design/isu_cell.sv */
module isu_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk,
  input  isu_pkg::isu_cmd_t         cmd,
  input  logic [isu_pkg::DATA_W-1:0] left_value,
  input  logic [isu_pkg::DATA_W-1:0] right_value,
  input  logic [isu_pkg::DATA_W-1:0] head_value,
  output logic [isu_pkg::DATA_W-1:0] value,
  output logic [isu_pkg::DATA_W-1:0] rd_data,
  output logic                      match
);
  import isu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] NEXT_IDX = IDX_W'(IDX + 1);

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.act)
      A_WRITE: begin
        if (MY_IDX == cmd.pos) value_next = cmd.val;
      end
      A_INSERT: begin
        if (MY_IDX == cmd.pos) value_next = cmd.val;
        else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt) value_next = left_value;
      end
      A_REMOVE: begin
        if (MY_IDX >= cmd.pos && NEXT_IDX < cmd.cnt) value_next = right_value;
      end
      A_ROTATE: begin
        if (MY_IDX < cmd.pos) value_next = right_value;
        else if (MY_IDX == cmd.pos) value_next = head_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign rd_data = (MY_IDX == cmd.rd_idx) ? value : '0;
  assign match = (MY_IDX < cmd.cnt) && (value == cmd.val);

endmodule

/* design/isu_chain.sv */
module isu_chain #(
  parameter int unsigned CAPACITY = isu_pkg::DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  isu_pkg::isu_cmd_t          cmd,
  output logic [CAPACITY-1:0]        match,
  output logic [isu_pkg::DATA_W-1:0] rd_data
);
  import isu_pkg::*;

  logic [DATA_W-1:0] values [CAPACITY];
  logic [DATA_W-1:0] reads  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = values[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = values[i+1];
    end
    isu_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .head_value  (values[0]),
      .value       (values[i]),
      .rd_data     (reads[i]),
      .match       (match[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | reads[i];
    end
  end

endmodule

/* design/isu_checker.sv */
module isu_checker #(
  parameter int unsigned CAPACITY = isu_pkg::DEFAULT_CAPACITY
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [isu_pkg::DATA_W-1:0] result_value,
  input logic signed [isu_pkg::POS_W-1:0]  found_position,
  input logic [isu_pkg::POS_W-1:0]   list_length,
  input logic [isu_pkg::STAT_W-1:0]  status
);
  import isu_pkg::*;

  localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> list_length == CAP_LEN)
    else $error("full status with length below capacity");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> result_value == '0 && found_position == '0)
    else $error("rejected request carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(list_length))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 out_valid |->
      list_length == $past(list_length) || list_length == $past(list_length) + POS_W'(1)
      || list_length == $past(list_length) - POS_W'(1) || $past(rst))
    else $error("length moved by more than one");

endmodule

bind indexed_sequence_store_unit isu_checker #(.CAPACITY(CAPACITY)) u_isu_checker (.*);
